@@ rtl/core/vph_pkg.sv @@
package vph_pkg;

  // largest datagram accepted without the oversize status
  localparam int unsigned MAX_BYTES = 65536;

  // byte counter saturates at MAX_BYTES + 1
  localparam int unsigned CNT_W = $clog2(MAX_BYTES + 2);
  // lengths compared at the last byte; declared size is 18 bits
  localparam int unsigned LEN_W = (CNT_W > 18) ? CNT_W : 18;
  // byte offset just past the optional header words (28 at most)
  localparam int unsigned POS_W = 5;

  localparam int unsigned NUM_CODES = 15;

  localparam int unsigned FIFO_AW = 1;
  localparam int unsigned FIFO_DEPTH = 2 ** FIFO_AW;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_OVERSIZE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    FC_STATUS    = 4'd0,
    FC_TYPE      = 4'd1,
    FC_COUNT     = 4'd2,
    FC_SIZE      = 4'd3,
    FC_STREAM_ID = 4'd4,
    FC_OUI       = 4'd5,
    FC_INFO_CLS  = 4'd6,
    FC_PKT_CLS   = 4'd7,
    FC_INT_TS    = 4'd8,
    FC_FRAC_TS   = 4'd9,
    FC_TRAILER   = 4'd10,
    FC_TSI       = 4'd11,
    FC_TSF       = 4'd12,
    FC_PAY_OFS   = 4'd13,
    FC_PAY_BYTES = 4'd14
  } field_e;

  // one parsed datagram, handed from the byte side to the result side
  typedef struct packed {
    status_e            status;
    logic [31:0]        hdr;
    logic [31:0]        sid;
    logic [23:0]        oui;
    logic [31:0]        cls;
    logic [31:0]        tsi;
    logic [63:0]        frac;
    logic [31:0]        trl;
    logic [POS_W-1:0]   offset;
    logic [LEN_W-1:0]   pay;
  } rec_t;

  // packet types 1 and 3 to 7 carry a stream id
  function automatic logic has_stream(input logic [31:0] h);
    return !h[31] && (h[30:28] != 3'd0) && (h[30:28] != 3'd2);
  endfunction

  function automatic logic has_class(input logic [31:0] h);
    return h[27];
  endfunction

  function automatic logic has_trailer(input logic [31:0] h);
    return h[26];
  endfunction

  function automatic logic [1:0] tsi_of(input logic [31:0] h);
    return h[23:22];
  endfunction

  function automatic logic [1:0] tsf_of(input logic [31:0] h);
    return h[21:20];
  endfunction

endpackage

@@ rtl/core/vita49_packet_header_parser.sv @@
// vita-49 packet header parser
//
// input channel: one datagram byte per beat (data_byte_i) with last_byte_i on
// the final byte. a beat is taken when in_valid_i is high and in_stall_o is low.
// output channel: result beats of field_code_o / field_value_o, with
// last_result_o on the final result of a datagram, taken when out_valid_o is
// high and out_stall_i is low. per datagram the status comes first, then the
// decoded header fields that are present, then payload offset and byte count;
// a rejected or oversize datagram gives a single status beat.
// throughput: one input byte per cycle and one result beat per cycle. the byte
// side captures fields as they pass and only checks lengths on the last byte;
// a two-entry queue of parsed datagrams sits between it and the result side.
// the status beat passes from the queue through the result side's record register
// and then the output register. in_stall_o rises only for a last byte while two
// parsed datagrams are still queued; other bytes are always taken.
// a stall on the output holds the result register and fills the queue; the
// byte side keeps capturing until its next last byte.
// reset: asynchronous, clears the byte counter, the queue and the output valid.
module vita49_packet_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  field_code_o,
  output logic [63:0] field_value_o,
  output logic        last_result_o
);
  import vph_pkg::*;

  // parsed datagram handoff between byte side and result side
  rec_t push_rec, pop_rec;
  logic push, pop;
  logic full, empty;

  // byte capture, field placement and length checks
  vph_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .full_i      (full),
    .push_o      (push),
    .rec_o       (push_rec)
  );

  // decouples the two sides so each can stall on its own
  vph_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .full_o  (full),
    .pop_i   (pop),
    .rec_o   (pop_rec),
    .empty_o (empty)
  );

  // walks the present fields, one result beat per cycle while out_stall_i is low
  vph_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_i         (pop_rec),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .field_code_o  (field_code_o),
    .field_value_o (field_value_o),
    .last_result_o (last_result_o)
  );

endmodule

@@ rtl/core/vph_front.sv @@
module vph_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  input  logic          full_i,
  output logic          push_o,
  output vph_pkg::rec_t rec_o
);
  import vph_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      hdr_q, hdr_d;
  logic [31:0]      wsh_q, wsh_d;
  logic [31:0]      sid_q, sid_d;
  logic [23:0]      oui_q, oui_d;
  logic [31:0]      cls_q, cls_d;
  logic [31:0]      tsi_q, tsi_d;
  logic [63:0]      frac_q, frac_d;

  logic             accept;
  logic [POS_W-1:0] e_sid, e_cls, e_oui, e_tsi, e_end;
  logic [CNT_W-1:0] cnt_inc;

  logic [LEN_W-1:0] sz, off, tr, decl, end1, end2;
  logic             oversize, ok1, fail2, fail3;
  status_e          status;

  // only a last byte waits for queue room, the capture itself never blocks
  assign in_stall_o = full_i && last_byte_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    hdr_d = (cnt_q < CNT_W'(4)) ? {hdr_q[23:0], data_byte_i} : hdr_q;
    wsh_d = {wsh_q[23:0], data_byte_i};
    cnt_inc = (cnt_q <= CNT_W'(MAX_BYTES)) ? cnt_q + CNT_W'(1) : cnt_q;

    // region boundaries of the optional words
    e_sid = POS_W'(4) + (has_stream(hdr_d) ? POS_W'(4) : POS_W'(0));
    e_cls = e_sid + (has_class(hdr_d) ? POS_W'(8) : POS_W'(0));
    e_oui = e_cls - POS_W'(4);
    e_tsi = e_cls + ((tsi_of(hdr_d) != 2'd0) ? POS_W'(4) : POS_W'(0));
    e_end = e_tsi + ((tsf_of(hdr_d) != 2'd0) ? POS_W'(8) : POS_W'(0));

    sid_d  = sid_q;
    oui_d  = oui_q;
    cls_d  = cls_q;
    tsi_d  = tsi_q;
    frac_d = frac_q;
    if (cnt_q >= CNT_W'(4) && cnt_q < CNT_W'(e_end)) begin
      if (cnt_q < CNT_W'(e_sid)) begin
        sid_d = {sid_q[23:0], data_byte_i};
      end else if (cnt_q < CNT_W'(e_oui)) begin
        oui_d = {oui_q[15:0], data_byte_i};
      end else if (cnt_q < CNT_W'(e_cls)) begin
        cls_d = {cls_q[23:0], data_byte_i};
      end else if (cnt_q < CNT_W'(e_tsi)) begin
        tsi_d = {tsi_q[23:0], data_byte_i};
      end else begin
        frac_d = {frac_q[55:0], data_byte_i};
      end
    end

    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = last_byte_i ? '0 : cnt_inc;
    end
  end

  // length checks on the final byte
  always_comb begin
    sz       = LEN_W'(cnt_inc);
    off      = LEN_W'(e_end);
    tr       = has_trailer(hdr_d) ? LEN_W'(4) : LEN_W'(0);
    decl     = LEN_W'({hdr_d[15:0], 2'b00});
    oversize = cnt_inc > CNT_W'(MAX_BYTES);
    ok1      = (sz >= LEN_W'(4)) && (sz >= off + tr);
    end1     = ok1 ? sz - tr : sz;
    fail2    = decl > sz;
    end2     = (decl >= off && decl <= end1) ? decl - tr : end1;
    fail3    = end2 < off;
    if (oversize) begin
      status = ST_OVERSIZE;
    end else if (!ok1 || fail2 || fail3) begin
      status = ST_REJECT;
    end else begin
      status = ST_OK;
    end
  end

  assign push_o        = accept && last_byte_i;
  assign rec_o.status  = status;
  assign rec_o.hdr     = hdr_d;
  assign rec_o.sid     = sid_d;
  assign rec_o.oui     = oui_d;
  assign rec_o.cls     = cls_d;
  assign rec_o.tsi     = tsi_d;
  assign rec_o.frac    = frac_d;
  assign rec_o.trl     = wsh_d;
  assign rec_o.offset  = e_end;
  assign rec_o.pay     = end2 - off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      hdr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        hdr_q <= hdr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wsh_q  <= wsh_d;
      sid_q  <= sid_d;
      oui_q  <= oui_d;
      cls_q  <= cls_d;
      tsi_q  <= tsi_d;
      frac_q <= frac_d;
    end
  end

endmodule

@@ rtl/core/vph_fifo.sv @@
module vph_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vph_pkg::rec_t rec_i,
  output logic          full_o,
  input  logic          pop_i,
  output vph_pkg::rec_t rec_o,
  output logic          empty_o
);
  import vph_pkg::*;

  rec_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;

  assign full_o  = cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign rec_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + FIFO_AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (FIFO_AW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (FIFO_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

@@ rtl/core/vph_emit.sv @@
module vph_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vph_pkg::rec_t rec_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [3:0]    field_code_o,
  output logic [63:0]   field_value_o,
  output logic          last_result_o
);
  import vph_pkg::*;

  rec_t                 rec_q, rec_d;
  logic [NUM_CODES-1:0] mask_q, mask_d, rest;
  field_e               code_q, code_d, cur;
  logic [63:0]          value_q, value_d;
  logic                 last_q, last_d;
  logic                 valid_q, valid_d;
  logic                 adv, emit;

  // which result items a datagram produces
  function automatic logic [NUM_CODES-1:0] present(input rec_t r);
    logic [NUM_CODES-1:0] m;
    m = '0;
    m[FC_STATUS] = 1'b1;
    if (r.status == ST_OK) begin
      m[FC_TYPE]      = 1'b1;
      m[FC_COUNT]     = 1'b1;
      m[FC_SIZE]      = 1'b1;
      m[FC_STREAM_ID] = has_stream(r.hdr);
      m[FC_OUI]       = has_class(r.hdr);
      m[FC_INFO_CLS]  = has_class(r.hdr);
      m[FC_PKT_CLS]   = has_class(r.hdr);
      m[FC_INT_TS]    = tsi_of(r.hdr) != 2'd0;
      m[FC_FRAC_TS]   = tsf_of(r.hdr) != 2'd0;
      m[FC_TRAILER]   = has_trailer(r.hdr);
      m[FC_TSI]       = 1'b1;
      m[FC_TSF]       = 1'b1;
      m[FC_PAY_OFS]   = 1'b1;
      m[FC_PAY_BYTES] = 1'b1;
    end
    return m;
  endfunction

  // lowest pending code goes out next
  always_comb begin
    cur = FC_STATUS;
    for (int k = NUM_CODES - 1; k >= 0; k--) begin
      if (mask_q[k]) begin
        cur = field_e'(k);
      end
    end
  end

  assign rest  = mask_q & (mask_q - NUM_CODES'(1));
  assign adv   = !valid_q || !out_stall_i;
  assign emit  = adv && (mask_q != '0);
  assign pop_o = adv && ((mask_q == '0) || (rest == '0)) && !empty_i;

  always_comb begin
    unique case (cur)
      FC_STATUS:    value_d = 64'(rec_q.status);
      FC_TYPE:      value_d = 64'(rec_q.hdr[31:28]);
      FC_COUNT:     value_d = 64'(rec_q.hdr[19:16]);
      FC_SIZE:      value_d = 64'(rec_q.hdr[15:0]);
      FC_STREAM_ID: value_d = 64'(rec_q.sid);
      FC_OUI:       value_d = 64'(rec_q.oui);
      FC_INFO_CLS:  value_d = 64'(rec_q.cls[31:16]);
      FC_PKT_CLS:   value_d = 64'(rec_q.cls[15:0]);
      FC_INT_TS:    value_d = 64'(rec_q.tsi);
      FC_FRAC_TS:   value_d = rec_q.frac;
      FC_TRAILER:   value_d = 64'(rec_q.trl);
      FC_TSI:       value_d = 64'(tsi_of(rec_q.hdr));
      FC_TSF:       value_d = 64'(tsf_of(rec_q.hdr));
      FC_PAY_OFS:   value_d = 64'(rec_q.offset);
      FC_PAY_BYTES: value_d = 64'(rec_q.pay);
      default:      value_d = '0;
    endcase
  end

  always_comb begin
    mask_d  = mask_q;
    rec_d   = rec_q;
    valid_d = valid_q;
    code_d  = code_q;
    last_d  = last_q;
    if (emit) begin
      mask_d = rest;
      code_d = cur;
      last_d = rest == '0;
    end
    if (pop_o) begin
      mask_d = present(rec_i);
      rec_d  = rec_i;
    end
    if (adv) begin
      valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      mask_q  <= mask_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    if (emit) begin
      value_q <= value_d;
    end
    code_q <= code_d;
    last_q <= last_d;
  end

  assign out_valid_o   = valid_q;
  assign field_code_o  = code_q;
  assign field_value_o = value_q;
  assign last_result_o = last_q;

  a_status_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_stall_i && last_q) |=> (!valid_q || code_q == FC_STATUS))
    else $error("datagram results do not open with status");

  a_fail_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && code_q == FC_STATUS && value_q != 64'(ST_OK)) |-> last_q)
    else $error("failure status followed by more results");

endmodule
